// ----- hw/rtl/pooled_linear_classifier_head_macros.svh -----
// ----------------------------------------------------------------------------
// pooled linear classifier head assertion macros
// concurrent check wrappers, compiled out when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef POOLED_LINEAR_CLASSIFIER_HEAD_MACROS_SVH
`define POOLED_LINEAR_CLASSIFIER_HEAD_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define PLCH_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);
// next-cycle implication
`define PLCH_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define PLCH_ASSERT_NOW(lbl, pre, post, msg)
`define PLCH_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ----- hw/rtl/plch_pkg.sv -----
// ----------------------------------------------------------------------------
// plch_pkg
// types and constants of the pooled linear classifier head
// ----------------------------------------------------------------------------
package plch_pkg;

  localparam int FRAME_HEIGHT = 8;
  localparam int FRAME_WIDTH  = 8;
  localparam int CHANNELS     = 64;
  localparam int MAX_CLASSES  = 16;

  localparam int FRAME_ELEMS  = FRAME_HEIGHT * FRAME_WIDTH * CHANNELS;
  localparam int ELEM_W       = $clog2(FRAME_ELEMS + 1);
  localparam int CH_W         = $clog2(CHANNELS);
  localparam int CLS_W        = 4;
  localparam int WDEPTH       = 1024;
  localparam int WADDR_W      = 10;
  localparam int SUM_W        = 15;
  localparam int DIV_MAG_W    = 14;
  localparam int DIV_CNT_W    = $clog2(DIV_MAG_W);
  localparam int DVS_W        = 31;
  localparam int ACC_W        = 40;
  localparam int CFG_W        = 31;

  typedef enum logic [1:0] {
    CMD_ACT    = 2'd0,
    CMD_WEIGHT = 2'd1,
    CMD_BIAS   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic {
    REG_CLASS_COUNT = 1'b0,
    REG_DIVISOR     = 1'b1
  } reg_e;

  typedef struct packed {
    logic [1:0]        cmd;
    logic signed [7:0] activation;
    logic [9:0]        table_index;
    logic signed [7:0] weight;
    logic signed [31:0] bias;
  } in_t;

  typedef struct packed {
    logic [3:0]         class_index;
    logic signed [31:0] logit;
    logic [3:0]         best_class;
    logic               status;
    logic               last;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DRAIN, S_DRD, S_DSTART, S_DWAIT,
    S_BRD, S_BLD, S_MAC, S_MEND, S_EMIT, S_CLEAR
  } state_e;

endpackage

// ----- hw/rtl/plch_ram.sv -----
// ----------------------------------------------------------------------------
// plch_ram
// generic one-write one-read ram with registered read data
// ----------------------------------------------------------------------------
module plch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/plch_div.sv -----
// ----------------------------------------------------------------------------
// plch_div
// serial restoring divider, signed sum by unsigned divisor, truncating
// ----------------------------------------------------------------------------
module plch_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [plch_pkg::SUM_W-1:0] dividend_i,
  input  logic [plch_pkg::DVS_W-1:0]       divisor_i,
  output logic                             busy_o,
  output logic                             done_o,
  output logic signed [plch_pkg::SUM_W-1:0] quotient_o
);

  logic                               busy_q, busy_d;
  logic                               done_q, done_d;
  logic [plch_pkg::DIV_CNT_W-1:0]     cnt_q, cnt_d;
  logic [plch_pkg::SUM_W-1:0]         rem_q, rem_d;
  logic [plch_pkg::DIV_MAG_W-1:0]     quo_q, quo_d;
  logic                               neg_q, neg_d;
  logic [plch_pkg::DVS_W-1:0]         dvs_q, dvs_d;
  logic [plch_pkg::SUM_W-1:0]         mag;
  logic [plch_pkg::SUM_W-1:0]         cand;
  logic                               fits;

  always_comb begin
    mag    = dividend_i[plch_pkg::SUM_W-1] ? (~dividend_i + 1'b1) : dividend_i;
    cand   = {rem_q[plch_pkg::SUM_W-2:0], quo_q[plch_pkg::DIV_MAG_W-1]};
    fits   = {{(plch_pkg::DVS_W-plch_pkg::SUM_W){1'b0}}, cand} >= dvs_q;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    neg_d  = neg_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = plch_pkg::DIV_CNT_W'(plch_pkg::DIV_MAG_W - 1);
      rem_d  = '0;
      quo_d  = mag[plch_pkg::DIV_MAG_W-1:0];
      neg_d  = dividend_i[plch_pkg::SUM_W-1];
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // one quotient bit per cycle
      rem_d = fits ? (cand - dvs_q[plch_pkg::SUM_W-1:0]) : cand;
      quo_d = {quo_q[plch_pkg::DIV_MAG_W-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    neg_q <= neg_d;
    dvs_q <= dvs_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

// ----- hw/rtl/pooled_linear_classifier_head.sv -----
// ----------------------------------------------------------------------------
// pooled_linear_classifier_head
// global average pooling, fully connected layer and argmax over one frame
// ----------------------------------------------------------------------------
// Weight, bias and activation requests come in on one channel, one per cycle
// while a frame streams in; each activation is read-modified-written into a
// 64-entry channel sum ram. After the frame's last activation the input
// stalls for the scoring pass: each channel sum goes through a serial
// divider and the quotient is written back over the sum, then every class
// runs a multiply-accumulate over the channels with one weight ram read per
// cycle and then emits its result, which waits while the output stalls. One
// result per class, or an early last result with status set when a logit
// leaves int32. Channel sums start from zero through per-entry valid bits,
// cleared at reset and after each frame.
module pooled_linear_classifier_head (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  plch_pkg::in_t             in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output plch_pkg::out_t            out_data_o,
  input  logic                      cfg_we_i,
  input  logic                      cfg_index_i,
  input  logic [plch_pkg::CFG_W-1:0] cfg_wdata_i
);

  typedef struct packed {
    logic div_start;
    logic feat_we;
    logic ch_clr;
    logic ch_inc;
    logic cls_clr;
    logic cls_inc;
    logic acc_load;
    logic mac_issue;
    logic emit;
    logic frame_clr;
    logic best_clr;
  } ctl_t;

  plch_pkg::state_e state_q, state_d;
  ctl_t             ctl;

  // configuration
  logic [4:0]                   class_count_q;
  logic [plch_pkg::DVS_W-1:0]   divisor_q;
  logic [plch_pkg::CLS_W-1:0]   last_cls;
  logic [plch_pkg::DVS_W-1:0]   divisor_eff;

  // frame counters
  logic [plch_pkg::ELEM_W-1:0]  elem_cnt_q;
  logic [plch_pkg::CH_W-1:0]    ch_q;
  logic [plch_pkg::CLS_W-1:0]   cls_q;

  // channel sum ram and accumulate stage
  logic [plch_pkg::CHANNELS-1:0] valid_q;
  logic [plch_pkg::CH_W-1:0]     rd_addr_q, ch_raddr;
  logic [plch_pkg::SUM_W-1:0]    ch_rdata, rd_val;
  logic                          ch_we;
  logic [plch_pkg::CH_W-1:0]     ch_waddr;
  logic [plch_pkg::SUM_W-1:0]    ch_wdata;
  logic                          acc_vld_q;
  logic [plch_pkg::CH_W-1:0]     acc_ch_q;
  logic signed [7:0]             acc_act_q;
  logic                          fwd_vld_q;
  logic [plch_pkg::CH_W-1:0]     fwd_addr_q;
  logic [plch_pkg::SUM_W-1:0]    fwd_data_q;
  logic [plch_pkg::SUM_W-1:0]    acc_base, acc_sum;

  // tables
  logic                          w_we, b_we;
  logic [plch_pkg::WADDR_W-1:0]  w_raddr;
  logic [7:0]                    w_rdata;
  logic [31:0]                   b_rdata;

  // divider
  logic                             div_busy, div_done;
  logic signed [plch_pkg::SUM_W-1:0] div_quo;

  // dot product
  logic                             mac_vld_q;
  logic signed [plch_pkg::ACC_W-1:0] acc_q;
  logic signed [22:0]               prod;
  logic                             ovf;
  logic signed [31:0]               logit;
  logic signed [31:0]               best_logit_q;
  logic [plch_pkg::CLS_W-1:0]       best_idx_q;
  logic                             better;

  // output register
  logic           out_valid_q;
  plch_pkg::out_t out_q;
  logic           out_free;

  logic in_acc, act_acc, last_act;

  assign in_stall_o = (state_q != plch_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign act_acc    = in_acc && (plch_pkg::cmd_e'(in_data_i.cmd) == plch_pkg::CMD_ACT);
  assign last_act   = act_acc &&
                      (elem_cnt_q == plch_pkg::ELEM_W'(plch_pkg::FRAME_ELEMS - 1));
  assign out_free   = !out_valid_q || !out_stall_i;

  // clamp class count to 1..MAX_CLASSES, zero divisor acts as one
  always_comb begin
    if (class_count_q == '0) begin
      last_cls = '0;
    end else if (class_count_q > 5'(plch_pkg::MAX_CLASSES)) begin
      last_cls = plch_pkg::CLS_W'(plch_pkg::MAX_CLASSES - 1);
    end else begin
      last_cls = plch_pkg::CLS_W'(class_count_q - 5'd1);
    end
    divisor_eff = (divisor_q == '0) ? plch_pkg::DVS_W'(1) : divisor_q;
  end

  // logit checks
  assign ovf    = !((&acc_q[plch_pkg::ACC_W-1:31]) || !(|acc_q[plch_pkg::ACC_W-1:31]));
  assign logit  = acc_q[31:0];
  assign better = (cls_q == '0) || (logit > best_logit_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      plch_pkg::S_IDLE:   if (last_act) state_d = plch_pkg::S_DRAIN;
      plch_pkg::S_DRAIN:  state_d = plch_pkg::S_DRD;
      plch_pkg::S_DRD:    state_d = plch_pkg::S_DSTART;
      plch_pkg::S_DSTART: state_d = plch_pkg::S_DWAIT;
      plch_pkg::S_DWAIT: begin
        if (div_done) begin
          state_d = (ch_q == plch_pkg::CH_W'(plch_pkg::CHANNELS - 1)) ?
                    plch_pkg::S_BRD : plch_pkg::S_DRD;
        end
      end
      plch_pkg::S_BRD:    state_d = plch_pkg::S_BLD;
      plch_pkg::S_BLD:    state_d = plch_pkg::S_MAC;
      plch_pkg::S_MAC: begin
        if (ch_q == plch_pkg::CH_W'(plch_pkg::CHANNELS - 1)) state_d = plch_pkg::S_MEND;
      end
      plch_pkg::S_MEND:   state_d = plch_pkg::S_EMIT;
      plch_pkg::S_EMIT: begin
        if (out_free) begin
          state_d = (ovf || cls_q == last_cls) ? plch_pkg::S_CLEAR : plch_pkg::S_BRD;
        end
      end
      plch_pkg::S_CLEAR:  state_d = plch_pkg::S_IDLE;
      default:            state_d = plch_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctl = '0;
    unique case (state_q)
      plch_pkg::S_DRAIN: begin
        ctl.ch_clr   = 1'b1;
        ctl.cls_clr  = 1'b1;
        ctl.best_clr = 1'b1;
      end
      plch_pkg::S_DSTART: ctl.div_start = 1'b1;
      plch_pkg::S_DWAIT: begin
        if (div_done) begin
          ctl.feat_we = 1'b1;
          ctl.ch_inc  = 1'b1;
        end
      end
      plch_pkg::S_BLD:  ctl.acc_load = 1'b1;
      plch_pkg::S_MAC: begin
        ctl.mac_issue = 1'b1;
        ctl.ch_inc    = 1'b1;
      end
      plch_pkg::S_EMIT: begin
        if (out_free) begin
          ctl.emit    = 1'b1;
          ctl.cls_inc = 1'b1;
        end
      end
      plch_pkg::S_CLEAR: ctl.frame_clr = 1'b1;
      default: ctl = '0;
    endcase
  end

  // channel sum ram access: stream address while idle, sequencer after
  assign ch_raddr = in_stall_o ? ch_q : elem_cnt_q[plch_pkg::CH_W-1:0];
  assign rd_val   = valid_q[rd_addr_q] ? ch_rdata : '0;
  // same channel written on the edge of its read: take the written value
  assign acc_base = (fwd_vld_q && fwd_addr_q == acc_ch_q) ? fwd_data_q : rd_val;
  assign acc_sum  = acc_base + {{(plch_pkg::SUM_W-8){acc_act_q[7]}}, acc_act_q};
  assign ch_we    = acc_vld_q || ctl.feat_we;
  assign ch_waddr = acc_vld_q ? acc_ch_q : ch_q;
  assign ch_wdata = acc_vld_q ? acc_sum : div_quo;

  plch_ram #(.WIDTH(plch_pkg::SUM_W), .DEPTH(plch_pkg::CHANNELS)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (ch_we),
    .waddr_i (ch_waddr),
    .wdata_i (ch_wdata),
    .raddr_i (ch_raddr),
    .rdata_o (ch_rdata)
  );

  // weight index class*channels+channel spans the whole table
  assign w_raddr = plch_pkg::WADDR_W'(32'(cls_q) * plch_pkg::CHANNELS + 32'(ch_q));
  assign w_we    = in_acc && (plch_pkg::cmd_e'(in_data_i.cmd) == plch_pkg::CMD_WEIGHT);
  assign b_we    = in_acc && (plch_pkg::cmd_e'(in_data_i.cmd) == plch_pkg::CMD_BIAS) &&
                   (in_data_i.table_index < 10'(plch_pkg::MAX_CLASSES));

  plch_ram #(.WIDTH(8), .DEPTH(plch_pkg::WDEPTH)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (in_data_i.table_index),
    .wdata_i (in_data_i.weight),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  plch_ram #(.WIDTH(32), .DEPTH(plch_pkg::MAX_CLASSES)) u_bias_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (in_data_i.table_index[plch_pkg::CLS_W-1:0]),
    .wdata_i (in_data_i.bias),
    .raddr_i (cls_q),
    .rdata_o (b_rdata)
  );

  plch_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl.div_start),
    .dividend_i (rd_val),
    .divisor_i  (divisor_eff),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign prod = $signed(rd_val) * $signed(w_rdata);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= plch_pkg::S_IDLE;
      class_count_q <= 5'd1;
      divisor_q     <= plch_pkg::DVS_W'(1);
      elem_cnt_q    <= '0;
      ch_q          <= '0;
      cls_q         <= '0;
      valid_q       <= '0;
      acc_vld_q     <= 1'b0;
      fwd_vld_q     <= 1'b0;
      mac_vld_q     <= 1'b0;
      best_idx_q    <= '0;
      best_logit_q  <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (plch_pkg::reg_e'(cfg_index_i))
          plch_pkg::REG_CLASS_COUNT: class_count_q <= cfg_wdata_i[4:0];
          plch_pkg::REG_DIVISOR:     divisor_q     <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (ctl.frame_clr) begin
        elem_cnt_q <= '0;
      end else if (act_acc) begin
        elem_cnt_q <= elem_cnt_q + 1'b1;
      end
      if (ctl.ch_clr) begin
        ch_q <= '0;
      end else if (ctl.ch_inc) begin
        ch_q <= ch_q + 1'b1;
      end
      if (ctl.cls_clr || ctl.frame_clr) begin
        cls_q <= '0;
      end else if (ctl.cls_inc) begin
        cls_q <= cls_q + 1'b1;
      end
      if (ctl.frame_clr) begin
        valid_q <= '0;
      end else if (ch_we) begin
        valid_q[ch_waddr] <= 1'b1;
      end
      acc_vld_q <= act_acc;
      fwd_vld_q <= acc_vld_q;
      mac_vld_q <= ctl.mac_issue;
      if (ctl.best_clr) begin
        best_idx_q   <= '0;
        best_logit_q <= '0;
      end else if (ctl.emit && !ovf && better) begin
        best_idx_q   <= cls_q;
        best_logit_q <= logit;
      end
      if (ctl.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_addr_q  <= ch_raddr;
    acc_ch_q   <= elem_cnt_q[plch_pkg::CH_W-1:0];
    acc_act_q  <= in_data_i.activation;
    fwd_addr_q <= acc_ch_q;
    fwd_data_q <= acc_sum;
    if (ctl.acc_load) begin
      acc_q <= plch_pkg::ACC_W'($signed(b_rdata));
    end else if (mac_vld_q) begin
      acc_q <= acc_q + plch_pkg::ACC_W'(prod);
    end
    if (ctl.emit) begin
      out_q.class_index <= cls_q;
      out_q.logit       <= ovf ? 32'sd0 : logit;
      out_q.best_class  <= (!ovf && better) ? cls_q : best_idx_q;
      out_q.status      <= ovf;
      out_q.last        <= ovf || (cls_q == last_cls);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `include "pooled_linear_classifier_head_macros.svh"

  `PLCH_ASSERT_NOW(a_status_last, out_valid_o && out_data_o.status, out_data_o.last, "overflow result not last")
  `PLCH_ASSERT_NOW(a_best_le_cls, out_valid_o, out_data_o.best_class <= out_data_o.class_index, "argmax ahead of class")
  `PLCH_ASSERT_NEXT(a_frame_stall, last_act, in_stall_o, "input open after frame end")
  `PLCH_ASSERT_NOW(a_div_idle, ctl.div_start, !div_busy, "divider restarted while busy")

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks the pooled linear classifier head against its own scoring predictor
// ----------------------------------------------------------------------------
// The weight and bias tables are written in full first, so no scoring pass
// ever reads an entry that was never written. After that come directed frames
// (all-max and all-min activations, forced logit overflow, zero divisor,
// class count zero and above the maximum) and then random phases. Every
// accepted request goes through the predictor, which queues the expected
// logits; the monitor checks each result against the oldest of them.
module testbench;
  import plch_pkg::*;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int SETTLE_CYCLES = 60;   // covers the sum clear after a frame
  localparam int HOLD_CYCLES = 3000;   // long output hold-off, fills the block

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  pooled_linear_classifier_head DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .in_data_i(in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o(out_data),
    .cfg_we_i(cfg_we),
    .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state: shadow copy of the tables, sums and registers
  int chan_sum [CHANNELS];
  logic signed [7:0] weight_mem [WDEPTH];
  logic signed [31:0] bias_mem [MAX_CLASSES];
  int elem_cnt;
  logic [4:0] class_cfg;
  logic [DVS_W-1:0] div_cfg;

  in_t request_q[$];   // requests waiting for the driver
  out_t logit_q[$];    // expected results, oldest first
  int errors = 0;

  // gap length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // pooling, dot products and argmax at the end of a frame
  function automatic void score_frame();
    int n;
    longint dv;
    longint acc;
    longint feat [CHANNELS];
    logic signed [31:0] best_l;
    logic [3:0] best_c;
    out_t e;
    bit stop;
    n = class_cfg;
    if (n == 0) n = 1;
    if (n > MAX_CLASSES) n = MAX_CLASSES;
    dv = (div_cfg == 0) ? 1 : longint'(div_cfg);
    for (int ch = 0; ch < CHANNELS; ch++) feat[ch] = longint'(chan_sum[ch]) / dv;
    best_l = 0;
    best_c = 0;
    stop = 0;
    for (int c = 0; c < n && !stop; c++) begin
      acc = longint'(bias_mem[c]);
      for (int ch = 0; ch < CHANNELS; ch++)
        acc += feat[ch] * longint'(weight_mem[(c * CHANNELS + ch) % WDEPTH]);
      e.class_index = c[3:0];
      if (acc < -64'sd2147483648 || acc > 64'sd2147483647) begin
        // overflow ends the frame with a flagged zero logit
        e.logit = 0;
        e.best_class = best_c;
        e.status = 1'b1;
        e.last = 1'b1;
        stop = 1;
      end else begin
        if (c == 0 || 32'(acc) > best_l) begin
          best_l = 32'(acc);
          best_c = c[3:0];
        end
        e.logit = 32'(acc);
        e.best_class = best_c;
        e.status = 1'b0;
        e.last = (c + 1 == n);
      end
      logit_q.push_back(e);
    end
    foreach (chan_sum[i]) chan_sum[i] = 0;
    elem_cnt = 0;
  endfunction

  function automatic void take_request(in_t r);
    case (r.cmd)
      CMD_WEIGHT: weight_mem[r.table_index] = r.weight;
      CMD_BIAS: if (r.table_index < MAX_CLASSES) bias_mem[r.table_index[3:0]] = r.bias;
      CMD_ACT: begin
        chan_sum[elem_cnt % CHANNELS] += int'($signed(r.activation));
        elem_cnt++;
        if (elem_cnt >= FRAME_ELEMS) score_frame();
      end
      default: ;  // unknown command is dropped
    endcase
  endfunction

  // driver: one request per handshake, random gaps between them
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) take_request(in_data);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          in_data <= request_q.pop_front();
          in_valid <= 1'b1;
          gap_left <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // monitor: compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni && out_valid && !out_stall) begin
      if (logit_q.size() == 0) begin
        $display("unexpected result for class %0d", out_data.class_index);
        errors++;
      end else begin
        e = logit_q.pop_front();
        if (out_data.class_index !== e.class_index)
          report("class_index", out_data.class_index, e.class_index);
        if (out_data.logit !== e.logit) report("logit", out_data.logit, e.logit);
        if (out_data.best_class !== e.best_class)
          report("best_class", out_data.best_class, e.best_class);
        if (out_data.status !== e.status) report("status", out_data.status, e.status);
        if (out_data.last !== e.last) report("last", out_data.last, e.last);
      end
    end
  end

  // output stall: random gaps, plus one long hold-off once armed
  logic rnd_stall = 1'b0;
  int stall_left = 0;
  int hold_cnt = 0;
  bit hold_arm = 0;
  bit hold_done = 0;
  always @(posedge clk_i) begin
    if (stall_left != 0) stall_left <= stall_left - 1;
    else stall_left <= pick_gap();
    rnd_stall <= (stall_left != 0);
  end
  always @(posedge clk_i) begin
    if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
    else if (hold_arm && !hold_done && logit_q.size() > 0) begin
      hold_cnt <= HOLD_CYCLES;
      hold_done <= 1;
    end
  end
  assign out_stall = rnd_stall | (hold_cnt != 0);

  // watchdog
  int cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---- stimulus helpers ----

  // unused fields carry random junk so every bit toggles
  task automatic push_req(logic [1:0] cmd, logic [7:0] act, logic [9:0] idx,
                          logic [7:0] w, logic [31:0] b);
    in_t r;
    r = in_t'({$urandom, $urandom});
    r.cmd = cmd;
    if (cmd == CMD_ACT) r.activation = act;
    if (cmd != CMD_ACT) r.table_index = idx;
    if (cmd == CMD_WEIGHT) r.weight = w;
    if (cmd == CMD_BIAS) r.bias = b;
    request_q.push_back(r);
  endtask

  function automatic logic [31:0] rand_bias();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 400000)) - 200000);
  endfunction

  // fill mode: 0 random, 1 all max, 2 all min; noise only in random frames
  task automatic push_frame(int fill);
    logic [7:0] a;
    for (int i = 0; i < FRAME_ELEMS; i++) begin
      a = (fill == 1) ? 8'sd127 : (fill == 2) ? -8'sd128 : 8'($urandom);
      if (fill == 0 && $urandom_range(0, 199) == 0)
        push_req(CMD_NONE, 0, 0, 0, 0);
      if (fill == 0 && $urandom_range(0, 499) == 0)
        push_req(CMD_WEIGHT, 0, 10'($urandom), 8'($urandom), 0);
      push_req(CMD_ACT, a, 0, 0, 0);
    end
  endtask

  task automatic random_writes(int count);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 3))
        0: push_req(CMD_BIAS, 0, 10'($urandom_range(0, 1023)), 0, rand_bias());
        1: push_req(CMD_NONE, 0, 0, 0, 0);
        default: push_req(CMD_WEIGHT, 0, 10'($urandom), 8'($urandom), 0);
      endcase
    end
  endtask

  // sender pause: nothing queued, nothing in flight, then settle
  task automatic wait_idle();
    do @(negedge clk_i);
    while (request_q.size() != 0 || in_valid || logit_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == REG_CLASS_COUNT) class_cfg = value[4:0];
    else div_cfg = value[DVS_W-1:0];
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  initial begin
    foreach (chan_sum[i]) chan_sum[i] = 0;
    elem_cnt = 0;
    class_cfg = 1;
    div_cfg = 1;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    write_reg(REG_CLASS_COUNT, 16);
    write_reg(REG_DIVISOR, 1);

    // directed: noise, ignored bias indexes, extremes
    push_req(CMD_NONE, 0, 0, 0, 0);
    push_req(CMD_BIAS, 0, 10'd1023, 0, 32'h7fffffff);
    push_req(CMD_BIAS, 0, 10'd16, 0, 32'h80000000);
    push_req(CMD_WEIGHT, 0, 10'd1023, 8'h80, 0);
    push_req(CMD_WEIGHT, 0, 10'd0, 8'h7f, 0);
    // full tables so no scoring pass reads an unwritten entry
    for (int i = 0; i < WDEPTH; i++) push_req(CMD_WEIGHT, 0, 10'(i), 8'($urandom), 0);
    for (int c = 0; c < MAX_CLASSES; c++) push_req(CMD_BIAS, 0, 10'(c), 0, rand_bias());
    push_req(CMD_BIAS, 0, 10'd13, 0, 32'h80000000);  // min bias, large headroom
    push_frame(1);
    push_frame(2);
    wait_idle();

    // zero class count and zero divisor
    write_reg(REG_CLASS_COUNT, 0);
    write_reg(REG_DIVISOR, 0);
    push_frame(0);
    wait_idle();

    // class count above the maximum, largest divisor: logits are the biases
    write_reg(REG_CLASS_COUNT, 31);
    write_reg(REG_DIVISOR, 31'h7fffffff);
    push_frame(0);
    wait_idle();

    // forced overflow on class 2: max bias with all-positive products
    write_reg(REG_CLASS_COUNT, 16);
    write_reg(REG_DIVISOR, 1);
    for (int ch = 0; ch < CHANNELS; ch++)
      push_req(CMD_WEIGHT, 0, 10'(2 * CHANNELS + ch), 8'sd127, 0);
    push_req(CMD_BIAS, 0, 10'd2, 0, 32'h7fffffff);
    push_frame(1);
    wait_idle();

    // long output hold-off while the next frame keeps coming
    write_reg(REG_CLASS_COUNT, 16);
    write_reg(REG_DIVISOR, $urandom_range(1, 300));
    random_writes(40);
    hold_arm = 1;
    push_frame(0);
    push_frame(0);
    wait_idle();

    // random phases
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_CLASS_COUNT, $urandom_range(0, 31));
      write_reg(REG_DIVISOR, ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                          : $urandom_range(1, 200));
      random_writes(20);
      push_frame(0);
      wait_idle();
    end

    repeat (100) @(negedge clk_i);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
